// ===== sv/dersig_pkg.sv =====
// Shared types and constants for the lax DER signature parser.
package dersig_pkg;

  localparam int unsigned SCALAR_BYTES = 32;
  localparam int unsigned SCALAR_BITS  = SCALAR_BYTES * 8;
  localparam int unsigned QDEPTH       = 2;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;

  localparam logic [3:0][63:0] GROUP_ORDER = {
    64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFE,
    64'hBAAE_DCE6_AF48_A03B,
    64'hBFD2_5E8C_D036_4141
  };

  typedef enum logic [3:0] {
    PH_SEQ_TAG,
    PH_SEQ_LEN,
    PH_SEQ_SKIP,
    PH_R_TAG,
    PH_R_LEN,
    PH_R_LENX,
    PH_R_DATA,
    PH_S_TAG,
    PH_S_LEN,
    PH_S_LENX,
    PH_S_DATA,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic        parse_ok;
    logic        overflow;
    logic [63:0] r_word_3;
    logic [63:0] r_word_2;
    logic [63:0] r_word_1;
    logic [63:0] r_word_0;
    logic [63:0] s_word_3;
    logic [63:0] s_word_2;
    logic [63:0] s_word_1;
    logic [63:0] s_word_0;
  } result_t;

  typedef struct packed {
    logic                   ok;
    logic                   too_long;
    logic [SCALAR_BITS-1:0] r;
    logic [SCALAR_BITS-1:0] s;
  } entry_t;

endpackage

// ===== sv/der_ecdsa_signature_lax_parser_core.sv =====
// Top level of the lax DER signature parser.
// Throughput: one signature byte per cycle while the queue is not full;
// a result may follow every cycle while result_ready is held high.
// The two-entry queue between parser and range check sets when bytes stall.
// Reset: synchronous rst returns the parser to the sequence tag and empties
// the queue and the output stages.
module der_ecdsa_signature_lax_parser_core #(
  parameter int unsigned LENGTH_BITS = 56
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  dersig_pkg::byte_t   byte_data,
  output logic                result_valid,
  input  logic                result_ready,
  output dersig_pkg::result_t result_data
);

  logic               q_full, push, head_valid, head_ready;
  dersig_pkg::entry_t push_entry, head;

  dersig_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  dersig_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .head_valid(head_valid),
    .head_ready(head_ready),
    .head      (head)
  );

  dersig_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_ready  (head_ready),
    .head        (head),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

endmodule

// ===== sv/dersig_front.sv =====
// Byte-wise parse state machine; emits one entry per signature.
module dersig_front #(
  parameter int unsigned LENGTH_BITS = 56
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_ready,
  input  dersig_pkg::byte_t       byte_data,
  input  logic                    q_full,
  output logic                    push,
  output dersig_pkg::entry_t      push_entry
);

  localparam int unsigned LEN_LIMIT = LENGTH_BITS / 8;
  localparam int unsigned SB = dersig_pkg::SCALAR_BITS;

  dersig_pkg::phase_t     phase, phase_next;
  logic [6:0]             lbl, lbl_next;
  logic [LENGTH_BITS-1:0] clen, clen_next;
  logic                   sig, sig_next;
  logic [5:0]             cnt, cnt_next;
  logic [SB-1:0]          r, r_next, s, s_next;
  logic                   tl, tl_next;
  logic                   fail, fail_next;

  logic                   take;
  logic                   is_s;
  logic [7:0]             b;
  dersig_pkg::phase_t     ph_tag_after, ph_data, ph_lenx;

  assign byte_ready = !q_full;
  assign take       = byte_valid && byte_ready;
  assign push       = take && byte_data.last_byte;
  assign b          = byte_data.in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dersig_pkg::PH_SEQ_TAG;
      lbl   <= '0;
      clen  <= '0;
      sig   <= 1'b0;
      cnt   <= '0;
      r     <= '0;
      s     <= '0;
      tl    <= 1'b0;
      fail  <= 1'b0;
    end else if (take) begin
      if (byte_data.last_byte) begin
        phase <= dersig_pkg::PH_SEQ_TAG;
        lbl   <= '0;
        clen  <= '0;
        sig   <= 1'b0;
        cnt   <= '0;
        r     <= '0;
        s     <= '0;
        tl    <= 1'b0;
        fail  <= 1'b0;
      end else begin
        phase <= phase_next;
        lbl   <= lbl_next;
        clen  <= clen_next;
        sig   <= sig_next;
        cnt   <= cnt_next;
        r     <= r_next;
        s     <= s_next;
        tl    <= tl_next;
        fail  <= fail_next;
      end
    end
  end

  always_comb begin
    is_s = (phase == dersig_pkg::PH_S_LEN) || (phase == dersig_pkg::PH_S_LENX) ||
           (phase == dersig_pkg::PH_S_DATA);
    ph_tag_after = is_s ? dersig_pkg::PH_DONE : dersig_pkg::PH_S_TAG;
    ph_data      = is_s ? dersig_pkg::PH_S_DATA : dersig_pkg::PH_R_DATA;
    ph_lenx      = is_s ? dersig_pkg::PH_S_LENX : dersig_pkg::PH_R_LENX;

    phase_next = phase;
    lbl_next   = lbl;
    clen_next  = clen;
    sig_next   = sig;
    cnt_next   = cnt;
    r_next     = r;
    s_next     = s;
    tl_next    = tl;
    fail_next  = fail;

    if (!fail) begin
      case (phase)
        dersig_pkg::PH_SEQ_TAG: begin
          if (b != dersig_pkg::TAG_SEQUENCE) fail_next = 1'b1;
          else phase_next = dersig_pkg::PH_SEQ_LEN;
        end
        dersig_pkg::PH_SEQ_LEN: begin
          if (b[7] && (b[6:0] != 7'd0)) begin
            lbl_next   = b[6:0];
            phase_next = dersig_pkg::PH_SEQ_SKIP;
          end else begin
            phase_next = dersig_pkg::PH_R_TAG;
          end
        end
        dersig_pkg::PH_SEQ_SKIP: begin
          lbl_next = lbl - 7'd1;
          if (lbl_next == 7'd0) phase_next = dersig_pkg::PH_R_TAG;
        end
        dersig_pkg::PH_R_TAG: begin
          if (b != dersig_pkg::TAG_INTEGER) fail_next = 1'b1;
          else phase_next = dersig_pkg::PH_R_LEN;
        end
        dersig_pkg::PH_S_TAG: begin
          if (b != dersig_pkg::TAG_INTEGER) fail_next = 1'b1;
          else phase_next = dersig_pkg::PH_S_LEN;
        end
        dersig_pkg::PH_R_LEN, dersig_pkg::PH_S_LEN: begin
          clen_next = '0;
          sig_next  = 1'b0;
          cnt_next  = '0;
          if (b[7] && (b[6:0] != 7'd0)) begin
            lbl_next   = b[6:0];
            phase_next = ph_lenx;
          end else begin
            if (!b[7]) clen_next = LENGTH_BITS'(b);
            phase_next = (clen_next == '0) ? ph_tag_after : ph_data;
          end
        end
        dersig_pkg::PH_R_LENX, dersig_pkg::PH_S_LENX: begin
          if ((b != 8'd0) || sig) begin
            sig_next = 1'b1;
            cnt_next = cnt + 6'd1;
            if (cnt_next >= 6'(LEN_LIMIT)) fail_next = 1'b1;
            else clen_next = {clen[LENGTH_BITS-9:0], b};
          end
          if (!fail_next) begin
            lbl_next = lbl - 7'd1;
            if (lbl_next == 7'd0) begin
              sig_next   = 1'b0;
              cnt_next   = '0;
              phase_next = (clen_next == '0) ? ph_tag_after : ph_data;
            end
          end
        end
        dersig_pkg::PH_R_DATA, dersig_pkg::PH_S_DATA: begin
          if ((b != 8'd0) || sig) begin
            sig_next = 1'b1;
            if (cnt[5]) begin
              tl_next = 1'b1;
            end else begin
              cnt_next = cnt + 6'd1;
              if (is_s) s_next = {s[SB-9:0], b};
              else r_next = {r[SB-9:0], b};
            end
          end
          clen_next = clen - LENGTH_BITS'(1);
          if (clen_next == '0) phase_next = ph_tag_after;
        end
        default: begin
        end
      endcase
    end

    push_entry.ok       = !fail_next && (phase_next == dersig_pkg::PH_DONE);
    push_entry.too_long = tl_next;
    push_entry.r        = r_next;
    push_entry.s        = s_next;
  end

endmodule

// ===== sv/dersig_queue.sv =====
// Short register queue between the parser and the range check.
module dersig_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dersig_pkg::entry_t push_entry,
  output logic               full,
  output logic               head_valid,
  input  logic               head_ready,
  output dersig_pkg::entry_t head
);

  localparam int unsigned PW = (dersig_pkg::QDEPTH > 1) ? $clog2(dersig_pkg::QDEPTH) : 1;
  localparam int unsigned CW = $clog2(dersig_pkg::QDEPTH + 1);

  dersig_pkg::entry_t slots [dersig_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full       = (count == CW'(dersig_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign pop        = head_valid && head_ready;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(dersig_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(dersig_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ===== sv/dersig_back.sv =====
// Group order check and result formatting, two register stages.
module dersig_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  output logic                head_ready,
  input  dersig_pkg::entry_t  head,
  output logic                result_valid,
  input  logic                result_ready,
  output dersig_pkg::result_t result_data
);

  localparam int unsigned SB = dersig_pkg::SCALAR_BITS;

  logic               s1_valid;
  dersig_pkg::entry_t s1_entry;
  logic [3:0]         s1_rlt, s1_req, s1_slt, s1_seq;
  logic [3:0]         rlt, req, slt, seq;
  logic               load1, load2;
  logic               r_below, s_below, ovf;
  dersig_pkg::result_t res;

  assign load2      = !result_valid || result_ready;
  assign head_ready = !s1_valid || load2;
  assign load1      = head_ready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rlt[i] = head.r[i*64 +: 64] < dersig_pkg::GROUP_ORDER[i];
      req[i] = head.r[i*64 +: 64] == dersig_pkg::GROUP_ORDER[i];
      slt[i] = head.s[i*64 +: 64] < dersig_pkg::GROUP_ORDER[i];
      seq[i] = head.s[i*64 +: 64] == dersig_pkg::GROUP_ORDER[i];
    end
  end

  always_comb begin
    r_below = s1_rlt[3] || (s1_req[3] && (s1_rlt[2] || (s1_req[2] &&
              (s1_rlt[1] || (s1_req[1] && s1_rlt[0])))));
    s_below = s1_slt[3] || (s1_seq[3] && (s1_slt[2] || (s1_seq[2] &&
              (s1_slt[1] || (s1_seq[1] && s1_slt[0])))));
    ovf = s1_entry.ok && (s1_entry.too_long || !r_below || !s_below);
    res = '0;
    res.parse_ok = s1_entry.ok;
    res.overflow = ovf;
    if (s1_entry.ok && !ovf) begin
      res.r_word_3 = s1_entry.r[SB-1 -: 64];
      res.r_word_2 = s1_entry.r[SB-65 -: 64];
      res.r_word_1 = s1_entry.r[SB-129 -: 64];
      res.r_word_0 = s1_entry.r[63:0];
      res.s_word_3 = s1_entry.s[SB-1 -: 64];
      res.s_word_2 = s1_entry.s[SB-65 -: 64];
      res.s_word_1 = s1_entry.s[SB-129 -: 64];
      res.s_word_0 = s1_entry.s[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load1) s1_valid <= head_valid;
      if (load2) result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && head_valid) begin
      s1_entry <= head;
      s1_rlt   <= rlt;
      s1_req   <= req;
      s1_slt   <= slt;
      s1_seq   <= seq;
    end
    if (load2 && s1_valid) result_data <= res;
  end

endmodule

// ===== sim/dersig_result_checker.sv =====
// Channel monitor, parse predictor and result comparison for the lax DER signature parser.
module dersig_result_checker #(
  parameter int unsigned LENGTH_BITS = 56
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic                byte_ready,
  input  dersig_pkg::byte_t   byte_data,
  input  logic                result_valid,
  input  logic                result_ready,
  input  dersig_pkg::result_t result_data,
  output int                  fails,
  output int                  outstanding,
  output int                  checked,
  output int                  n_overflow,
  output int                  n_rejected
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_LIMIT = LENGTH_BITS / 8;

  dersig_pkg::phase_t     phase;
  logic [6:0]             len_left;
  logic [LENGTH_BITS-1:0] body_len;
  bit                     seen_nz;
  int unsigned            nbytes;
  logic [255:0]           r_acc;
  logic [255:0]           s_acc;
  bit                     too_long;
  bit                     bad_fmt;

  dersig_pkg::result_t pending_results[$];
  int errs  = 0;
  int n_chk = 0;
  int n_ovf = 0;
  int n_rej = 0;

  function automatic void clear_parser();
    phase    = dersig_pkg::PH_SEQ_TAG;
    len_left = '0;
    body_len = '0;
    seen_nz  = 1'b0;
    nbytes   = 0;
    r_acc    = '0;
    s_acc    = '0;
    too_long = 1'b0;
    bad_fmt  = 1'b0;
  endfunction

  function automatic void open_scalar(bit is_s);
    seen_nz = 1'b0;
    nbytes  = 0;
    if (body_len == 0) begin
      phase = is_s ? dersig_pkg::PH_DONE : dersig_pkg::PH_S_TAG;
    end else begin
      phase = is_s ? dersig_pkg::PH_S_DATA : dersig_pkg::PH_R_DATA;
    end
  endfunction

  function automatic void take_length(logic [7:0] b, bit is_s);
    body_len = '0;
    seen_nz  = 1'b0;
    nbytes   = 0;
    if (b[7]) begin
      if (b[6:0] == 0) begin
        open_scalar(is_s);
      end else begin
        len_left = b[6:0];
        phase    = is_s ? dersig_pkg::PH_S_LENX : dersig_pkg::PH_R_LENX;
      end
    end else begin
      body_len = LENGTH_BITS'(b);
      open_scalar(is_s);
    end
  endfunction

  function automatic void take_length_byte(logic [7:0] b, bit is_s);
    if (b != 0 || seen_nz) begin
      seen_nz = 1'b1;
      nbytes++;
      if (nbytes >= LEN_LIMIT) begin
        bad_fmt = 1'b1;
        return;
      end
      body_len = {body_len[LENGTH_BITS-9:0], b};
    end
    len_left = len_left - 7'd1;
    if (len_left == 0) open_scalar(is_s);
  endfunction

  function automatic void take_scalar_byte(logic [7:0] b, bit is_s);
    if (b != 0 || seen_nz) begin
      seen_nz = 1'b1;
      if (nbytes >= dersig_pkg::SCALAR_BYTES) begin
        too_long = 1'b1;
      end else begin
        if (is_s) s_acc = {s_acc[247:0], b};
        else      r_acc = {r_acc[247:0], b};
        nbytes++;
      end
    end
    body_len = body_len - 1'b1;
    if (body_len == 0) phase = is_s ? dersig_pkg::PH_DONE : dersig_pkg::PH_S_TAG;
  endfunction

  function automatic void advance_parser(logic [7:0] b);
    if (bad_fmt) return;
    case (phase)
      dersig_pkg::PH_SEQ_TAG: begin
        if (b != dersig_pkg::TAG_SEQUENCE) bad_fmt = 1'b1;
        else phase = dersig_pkg::PH_SEQ_LEN;
      end
      dersig_pkg::PH_SEQ_LEN: begin
        if (b[7] && b[6:0] != 0) begin
          len_left = b[6:0];
          phase    = dersig_pkg::PH_SEQ_SKIP;
        end else begin
          phase = dersig_pkg::PH_R_TAG;
        end
      end
      dersig_pkg::PH_SEQ_SKIP: begin
        len_left = len_left - 7'd1;
        if (len_left == 0) phase = dersig_pkg::PH_R_TAG;
      end
      dersig_pkg::PH_R_TAG: begin
        if (b != dersig_pkg::TAG_INTEGER) bad_fmt = 1'b1;
        else phase = dersig_pkg::PH_R_LEN;
      end
      dersig_pkg::PH_R_LEN:  take_length(b, 1'b0);
      dersig_pkg::PH_R_LENX: take_length_byte(b, 1'b0);
      dersig_pkg::PH_R_DATA: take_scalar_byte(b, 1'b0);
      dersig_pkg::PH_S_TAG: begin
        if (b != dersig_pkg::TAG_INTEGER) bad_fmt = 1'b1;
        else phase = dersig_pkg::PH_S_LEN;
      end
      dersig_pkg::PH_S_LEN:  take_length(b, 1'b1);
      dersig_pkg::PH_S_LENX: take_length_byte(b, 1'b1);
      dersig_pkg::PH_S_DATA: take_scalar_byte(b, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void close_signature();
    dersig_pkg::result_t want;
    want = '0;
    if (!bad_fmt && phase == dersig_pkg::PH_DONE) begin
      want.parse_ok = 1'b1;
      if (too_long || r_acc >= dersig_pkg::GROUP_ORDER ||
          s_acc >= dersig_pkg::GROUP_ORDER) begin
        want.overflow = 1'b1;
      end else begin
        want.r_word_3 = r_acc[255:192];
        want.r_word_2 = r_acc[191:128];
        want.r_word_1 = r_acc[127:64];
        want.r_word_0 = r_acc[63:0];
        want.s_word_3 = s_acc[255:192];
        want.s_word_2 = s_acc[191:128];
        want.s_word_1 = s_acc[127:64];
        want.s_word_0 = s_acc[63:0];
      end
    end
    pending_results.push_back(want);
    clear_parser();
  endfunction

  function automatic void check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      errs++;
      if (errs <= 10) begin
        $display("result %0d field %s: expected %h, got %h", n_chk, name, want, got);
      end
    end
  endfunction

  function automatic void compare_result(dersig_pkg::result_t got);
    dersig_pkg::result_t want;
    want = pending_results.pop_front();
    check_field("parse_ok", 64'(got.parse_ok), 64'(want.parse_ok));
    check_field("overflow", 64'(got.overflow), 64'(want.overflow));
    check_field("r_word_3", got.r_word_3, want.r_word_3);
    check_field("r_word_2", got.r_word_2, want.r_word_2);
    check_field("r_word_1", got.r_word_1, want.r_word_1);
    check_field("r_word_0", got.r_word_0, want.r_word_0);
    check_field("s_word_3", got.s_word_3, want.s_word_3);
    check_field("s_word_2", got.s_word_2, want.s_word_2);
    check_field("s_word_1", got.s_word_1, want.s_word_1);
    check_field("s_word_0", got.s_word_0, want.s_word_0);
    n_chk++;
    if (want.overflow) n_ovf++;
    if (!want.parse_ok) n_rej++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      pending_results.delete();
    end else begin
      if (result_valid === 1'b1 && result_ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          errs++;
          if (errs <= 10) $display("result with nothing pending: %h", result_data);
        end else begin
          compare_result(result_data);
        end
      end
      if (byte_valid === 1'b1 && byte_ready === 1'b1) begin
        advance_parser(byte_data.in_byte);
        if (byte_data.last_byte) close_signature();
      end
    end
    fails       <= errs;
    outstanding <= pending_results.size();
    checked     <= n_chk;
    n_overflow  <= n_ovf;
    n_rejected  <= n_rej;
  end

endmodule

// ===== sim/der_ecdsa_signature_lax_parser_core_tb.sv =====
// Top of the lax DER signature parser testbench: clock, reset, request stimulus and verdict.
module der_ecdsa_signature_lax_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    K_RAND, K_PADDED, K_SHORT, K_HIGH, K_EMPTY, K_ZEROS,
    K_ORDER, K_ORDER_M1, K_ALL_FF, K_TOO_LONG, K_ONE
  } scalar_kind_t;

  typedef enum int {LEN_SHORT, LEN_LONG, LEN_PADDED, LEN_HUGE} len_form_t;

  typedef logic [7:0] octet_q_t[$];

  localparam int unsigned LEN_BITS     = 56;
  localparam int          TARGET_BYTES = 1350;
  localparam int          DRAIN_CYCLES = 20;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                byte_valid   = 1'b0;
  logic                byte_ready;
  dersig_pkg::byte_t   byte_data    = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  dersig_pkg::result_t result_data;

  int fails;
  int outstanding;
  int checked;
  int n_overflow;
  int n_rejected;

  octet_q_t     frame;
  int           pos_r_tag;
  int           pos_s_tag;
  bit           src_calm   = 1'b0;
  int           sink_left  = 0;
  int           sink_pick;
  int           n_bytes    = 0;
  int           n_sigs     = 0;
  logic [255:0] order_val  = dersig_pkg::GROUP_ORDER;

  always #1 clk = ~clk;

  der_ecdsa_signature_lax_parser_core #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  dersig_result_checker #(.LENGTH_BITS(LEN_BITS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .fails        (fails),
    .outstanding  (outstanding),
    .checked      (checked),
    .n_overflow   (n_overflow),
    .n_rejected   (n_rejected)
  );

  always @(posedge clk) begin
    if (sink_left > 0) begin
      sink_left <= sink_left - 1;
    end else begin
      sink_pick = $urandom_range(0, 99);
      if (sink_pick < 15) begin
        result_ready <= 1'b1;
        sink_left    <= $urandom_range(20, 80);
      end else if (sink_pick < 60) begin
        result_ready <= 1'b1;
        sink_left    <= $urandom_range(0, 6);
      end else if (sink_pick < 93) begin
        result_ready <= 1'b0;
        sink_left    <= $urandom_range(0, 3);
      end else begin
        result_ready <= 1'b0;
        sink_left    <= $urandom_range(10, 40);
      end
    end
  end

  function automatic logic [7:0] rand_octet();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic octet_q_t scalar_body(scalar_kind_t k);
    octet_q_t     q;
    logic [255:0] v;
    case (k)
      K_RAND: repeat (32) q.push_back(rand_octet());
      K_PADDED: begin
        repeat ($urandom_range(1, 4)) q.push_back(8'h00);
        repeat (32) q.push_back(rand_octet());
      end
      K_SHORT: repeat ($urandom_range(1, 8)) q.push_back(rand_octet());
      K_HIGH: begin
        repeat (15) q.push_back(8'hFF);
        q.push_back($urandom_range(0, 1) ? 8'hFF : 8'hFE);
        repeat (16) q.push_back(rand_octet());
      end
      K_EMPTY: ;
      K_ZEROS: repeat ($urandom_range(1, 3)) q.push_back(8'h00);
      K_ORDER, K_ORDER_M1: begin
        v = (k == K_ORDER) ? order_val : order_val - 1;
        for (int n = 31; n >= 0; n--) q.push_back(v[n*8 +: 8]);
      end
      K_ALL_FF: repeat (32) q.push_back(8'hFF);
      K_TOO_LONG: begin
        q.push_back(8'($urandom_range(1, 255)));
        repeat (32) q.push_back(rand_octet());
      end
      default: q.push_back(8'h01);
    endcase
    return q;
  endfunction

  function automatic void push_len(int n, len_form_t f);
    octet_q_t digits;
    int       v;
    int       pad;
    int       cnt;
    pad = 0;
    if (f == LEN_SHORT && n < 128) begin
      frame.push_back(8'(n));
      return;
    end
    if (f == LEN_HUGE) begin
      cnt = $urandom_range(6, 8);
      frame.push_back(8'h80 | 8'(cnt));
      frame.push_back(8'($urandom_range(1, 255)));
      repeat (cnt - 1) frame.push_back(rand_octet());
      return;
    end
    if (f == LEN_PADDED) pad = $urandom_range(1, 9);
    v = n;
    while (v > 0) begin
      digits.push_front(8'(v));
      v = v >> 8;
    end
    frame.push_back(8'h80 | 8'(digits.size() + pad));
    repeat (pad) frame.push_back(8'h00);
    foreach (digits[i]) frame.push_back(digits[i]);
  endfunction

  function automatic int push_int(scalar_kind_t k, len_form_t f);
    octet_q_t body;
    int       tag_at;
    body   = scalar_body(k);
    tag_at = frame.size();
    frame.push_back(dersig_pkg::TAG_INTEGER);
    push_len(body.size(), f);
    foreach (body[i]) frame.push_back(body[i]);
    return tag_at;
  endfunction

  function automatic void make_frame(scalar_kind_t kr, len_form_t fr,
                                     scalar_kind_t ks, len_form_t fs);
    int r;
    frame.delete();
    frame.push_back(dersig_pkg::TAG_SEQUENCE);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      frame.push_back(8'($urandom_range(0, 127)));
    end else if (r < 60) begin
      frame.push_back(8'h80);
    end else begin
      r = (r < 95) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      frame.push_back(8'h80 | 8'(r));
      repeat (r) frame.push_back(rand_octet());
    end
    pos_r_tag = push_int(kr, fr);
    pos_s_tag = push_int(ks, fs);
  endfunction

  function automatic scalar_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return K_RAND;
    if (r < 45) return K_PADDED;
    if (r < 65) return K_SHORT;
    if (r < 75) return K_HIGH;
    if (r < 79) return K_EMPTY;
    if (r < 83) return K_ZEROS;
    if (r < 86) return K_ORDER;
    if (r < 89) return K_ORDER_M1;
    if (r < 92) return K_ALL_FF;
    if (r < 97) return K_TOO_LONG;
    return K_ONE;
  endfunction

  function automatic len_form_t pick_form();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58) return LEN_SHORT;
    if (r < 82) return LEN_LONG;
    if (r < 97) return LEN_PADDED;
    return LEN_HUGE;
  endfunction

  function automatic void truncate_frame();
    int cut;
    cut = $urandom_range(1, frame.size() - 1);
    while (frame.size() > cut) void'(frame.pop_back());
  endfunction

  function automatic void random_frame();
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      frame.delete();
      repeat ($urandom_range(1, 12)) frame.push_back(rand_octet());
      if ($urandom_range(0, 2) == 0) frame[0] = dersig_pkg::TAG_SEQUENCE;
      return;
    end
    make_frame(pick_kind(), pick_form(), pick_kind(), pick_form());
    if (r < 62) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) frame.push_back(rand_octet());
      end
    end else if (r < 76) begin
      truncate_frame();
    end else if (r < 85) begin
      case ($urandom_range(0, 2))
        0:       p = 0;
        1:       p = pos_r_tag;
        default: p = pos_s_tag;
      endcase
      frame[p] ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) truncate_frame();
    end else begin
      frame[$urandom_range(1, frame.size() - 1)] = rand_octet();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic put_byte(dersig_pkg::byte_t b);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      byte_data  <= 9'($urandom);
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    do @(posedge clk); while (byte_ready !== 1'b1);
    n_bytes++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) begin
      put_byte(dersig_pkg::byte_t'{in_byte: frame[i], last_byte: (i == frame.size() - 1)});
    end
    n_sigs++;
  endtask

  // hold off new requests until every pending result has been taken
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("timeout with %0d results still pending", outstanding);
    $display("der_ecdsa_signature_lax_parser_core_tb failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    frame = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
    send_frame();
    frame = '{8'h30, 8'h04, 8'h02, 8'h00, 8'h02, 8'h00};
    send_frame();
    frame = '{8'h30, 8'h04, 8'h02, 8'h80, 8'h02, 8'h80};
    send_frame();
    frame = '{8'h30, 8'h80, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
    send_frame();
    make_frame(K_PADDED, LEN_SHORT, K_RAND, LEN_SHORT);
    send_frame();
    make_frame(K_ORDER, LEN_SHORT, K_ONE, LEN_LONG);
    send_frame();
    make_frame(K_ONE, LEN_SHORT, K_ORDER_M1, LEN_PADDED);
    send_frame();
    make_frame(K_ALL_FF, LEN_LONG, K_SHORT, LEN_SHORT);
    send_frame();
    make_frame(K_SHORT, LEN_SHORT, K_TOO_LONG, LEN_SHORT);
    send_frame();
    make_frame(K_ZEROS, LEN_PADDED, K_EMPTY, LEN_LONG);
    send_frame();
    make_frame(K_HIGH, LEN_PADDED, K_PADDED, LEN_LONG);
    send_frame();
    frame = '{8'h30, 8'h10, 8'h02, 8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h01, 8'h7F, 8'h02, 8'h01, 8'h00};
    send_frame();
    frame = '{8'h30, 8'h10, 8'h02, 8'h87, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
              8'h06, 8'h07, 8'h08, 8'h09};
    send_frame();
    frame = '{8'h30, 8'h10, 8'h02, 8'h86, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h05, 8'h05};
    send_frame();
    frame = '{8'h30, 8'h00, 8'h02, 8'hFF};
    repeat (126) frame.push_back(8'h00);
    frame.push_back(8'h01);
    frame.push_back(8'h55);
    frame.push_back(dersig_pkg::TAG_INTEGER);
    frame.push_back(8'h01);
    frame.push_back(8'h01);
    send_frame();
    frame = '{8'h30, 8'hFF};
    repeat (127) frame.push_back(rand_octet());
    frame.push_back(dersig_pkg::TAG_INTEGER);
    frame.push_back(8'h01);
    frame.push_back(8'h01);
    frame.push_back(dersig_pkg::TAG_INTEGER);
    frame.push_back(8'h01);
    frame.push_back(8'h02);
    send_frame();
    frame = '{8'h31, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
    send_frame();
    frame = '{8'h30, 8'h06, 8'h03, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
    send_frame();
    frame = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h12, 8'h01, 8'h01};
    send_frame();
    frame = '{8'h30, 8'h06, 8'h02, 8'h01};
    send_frame();
    frame = '{8'h30};
    send_frame();
    frame = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01,
              8'hFF, 8'h00, 8'h30};
    send_frame();
    frame = '{8'h30, 8'h04, 8'h02, 8'h01, 8'h05, 8'h02, 8'h00};
    send_frame();
    drain();

    while (n_bytes < TARGET_BYTES) begin
      random_frame();
      src_calm = ($urandom_range(0, 4) == 0);
      send_frame();
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d signatures in %0d bytes", n_sigs, n_bytes);
    $display("%0d results checked, %0d overflow, %0d rejected",
             checked, n_overflow, n_rejected);
    if (fails == 0) begin
      $display("der_ecdsa_signature_lax_parser_core_tb passed");
    end else begin
      $display("der_ecdsa_signature_lax_parser_core_tb failed");
    end
    $finish;
  end

endmodule

// ===== der_ecdsa_signature_lax_parser_core.f =====
sv/dersig_pkg.sv
sv/dersig_front.sv
sv/dersig_queue.sv
sv/dersig_back.sv
sv/der_ecdsa_signature_lax_parser_core.sv
sim/dersig_result_checker.sv
sim/der_ecdsa_signature_lax_parser_core_tb.sv
